// File: hw/rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Password policy checker package
// Shared constants, register indexes and the byte classifier used by the
// password policy checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

   // Default length limit; the length and run counters saturate one above it.
   localparam int LENGTH_LIMIT_DEFAULT = 255;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int BYTE_W     = 8;
   localparam int CLASS_W    = 4;
   localparam int MIN_CLS_W  = 3;

   // One bit per character class.
   localparam logic [CLASS_W-1:0] CLS_LOWER = 4'b0001;
   localparam logic [CLASS_W-1:0] CLS_UPPER = 4'b0010;
   localparam logic [CLASS_W-1:0] CLS_DIGIT = 4'b0100;
   localparam logic [CLASS_W-1:0] CLS_OTHER = 4'b1000;

   // Register reset values.
   localparam logic [BYTE_W-1:0]    MIN_LENGTH_RESET   = 8'd0;
   localparam logic [BYTE_W-1:0]    MAX_LENGTH_RESET   = 8'd255;
   localparam logic [MIN_CLS_W-1:0] MIN_CLASSES_RESET  = 3'd0;
   localparam logic [CLASS_W-1:0]   REQUIRED_RESET     = 4'd0;
   localparam logic [CLASS_W-1:0]   FORBIDDEN_RESET    = 4'd0;
   localparam logic [BYTE_W-1:0]    MAX_REPEAT_RESET   = 8'd0;
   localparam logic [BYTE_W-1:0]    MAX_ASCENDING_RESET = 8'd0;

   // Register word indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_MIN_LENGTH    = 3'd0,
      REG_MAX_LENGTH    = 3'd1,
      REG_MIN_CLASSES   = 3'd2,
      REG_REQUIRED      = 3'd3,
      REG_FORBIDDEN     = 3'd4,
      REG_MAX_REPEAT    = 3'd5,
      REG_MAX_ASCENDING = 3'd6
   } reg_index_type;

   // Classifies one byte into exactly one class.
   function automatic logic [CLASS_W-1:0] class_of(input logic [BYTE_W-1:0] b);
      logic [CLASS_W-1:0] cls;
      if (b >= 8'h61 && b <= 8'h7A) begin
         cls = CLS_LOWER;
      end else if (b >= 8'h41 && b <= 8'h5A) begin
         cls = CLS_UPPER;
      end else if (b >= 8'h30 && b <= 8'h39) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/password_policy_checker_top.sv
// ----------------------------------------------------------------------------
// Password policy checker
// Checks a password, streamed one byte per request, against a configurable
// complexity policy and returns one pass/fail result per password.
// ----------------------------------------------------------------------------
//
// Usage:
//   The request channel (req_valid/req_ready) carries one password byte per
//   request together with a last flag. Only a request with the last flag set
//   produces a result, a single ok bit on the response channel
//   (rsp_valid/rsp_ready). All other requests just update the running state.
//   The policy registers are written over the APB-style port, and should only
//   be changed while no password is in flight.
// Timing:
//   Every byte is classified and folded into the running state in the cycle
//   it is accepted, so one request is taken every clock cycle while req_ready
//   is high. The result of a final byte is registered in the output register,
//   or in the skid register while the output register is held.
// Stalls and reset:
//   Results go into a two-entry queue (output register plus skid register),
//   so requests keep flowing while one result waits to be taken. Only when
//   both entries are full is req_ready dropped. Synchronous reset clears the
//   running state, the result queue and sets the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module password_policy_checker_top #(
   parameter int LENGTH_LIMIT = ppc_pkg::LENGTH_LIMIT_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Request channel
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [ppc_pkg::BYTE_W-1:0]          req_char_byte,
   input  wire                                 req_last_byte,
   // Response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_ok,
   // Register port
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [ppc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire  [ppc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ppc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   // The counters must hold LENGTH_LIMIT + 1, their saturation value.
   localparam int CNT_W = $clog2(LENGTH_LIMIT + 2);
   // Comparisons against the 8-bit limits run at the wider of the two widths.
   localparam int CMP_W = (CNT_W > ppc_pkg::BYTE_W) ? CNT_W : ppc_pkg::BYTE_W;
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(LENGTH_LIMIT + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // ------------------------------------------------------------------------
   // Policy registers
   // ------------------------------------------------------------------------
   logic [ppc_pkg::BYTE_W-1:0]    min_length_ff;
   logic [ppc_pkg::BYTE_W-1:0]    max_length_ff;
   logic [ppc_pkg::MIN_CLS_W-1:0] min_classes_ff;
   logic [ppc_pkg::CLASS_W-1:0]   required_ff;
   logic [ppc_pkg::CLASS_W-1:0]   forbidden_ff;
   logic [ppc_pkg::BYTE_W-1:0]    max_repeat_ff;
   logic [ppc_pkg::BYTE_W-1:0]    max_ascending_ff;

   logic                          csr_write;
   ppc_pkg::reg_index_type        csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = ppc_pkg::reg_index_type'(paddr[ppc_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff    <= ppc_pkg::MIN_LENGTH_RESET;
         max_length_ff    <= ppc_pkg::MAX_LENGTH_RESET;
         min_classes_ff   <= ppc_pkg::MIN_CLASSES_RESET;
         required_ff      <= ppc_pkg::REQUIRED_RESET;
         forbidden_ff     <= ppc_pkg::FORBIDDEN_RESET;
         max_repeat_ff    <= ppc_pkg::MAX_REPEAT_RESET;
         max_ascending_ff <= ppc_pkg::MAX_ASCENDING_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ppc_pkg::REG_MIN_LENGTH:    min_length_ff    <= pwdata[ppc_pkg::BYTE_W-1:0];
            ppc_pkg::REG_MAX_LENGTH:    max_length_ff    <= pwdata[ppc_pkg::BYTE_W-1:0];
            ppc_pkg::REG_MIN_CLASSES:   min_classes_ff   <= pwdata[ppc_pkg::MIN_CLS_W-1:0];
            ppc_pkg::REG_REQUIRED:      required_ff      <= pwdata[ppc_pkg::CLASS_W-1:0];
            ppc_pkg::REG_FORBIDDEN:     forbidden_ff     <= pwdata[ppc_pkg::CLASS_W-1:0];
            ppc_pkg::REG_MAX_REPEAT:    max_repeat_ff    <= pwdata[ppc_pkg::BYTE_W-1:0];
            ppc_pkg::REG_MAX_ASCENDING: max_ascending_ff <= pwdata[ppc_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back is a plain decode of the same word index.
   always_comb begin
      unique case (csr_index)
         ppc_pkg::REG_MIN_LENGTH:    prdata = ppc_pkg::CSR_DATA_W'(min_length_ff);
         ppc_pkg::REG_MAX_LENGTH:    prdata = ppc_pkg::CSR_DATA_W'(max_length_ff);
         ppc_pkg::REG_MIN_CLASSES:   prdata = ppc_pkg::CSR_DATA_W'(min_classes_ff);
         ppc_pkg::REG_REQUIRED:      prdata = ppc_pkg::CSR_DATA_W'(required_ff);
         ppc_pkg::REG_FORBIDDEN:     prdata = ppc_pkg::CSR_DATA_W'(forbidden_ff);
         ppc_pkg::REG_MAX_REPEAT:    prdata = ppc_pkg::CSR_DATA_W'(max_repeat_ff);
         ppc_pkg::REG_MAX_ASCENDING: prdata = ppc_pkg::CSR_DATA_W'(max_ascending_ff);
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Running password state
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0]              length_ff,   length_in;
   logic [ppc_pkg::CLASS_W-1:0]   classes_ff,  classes_in;
   logic [ppc_pkg::BYTE_W-1:0]    prev_ff;
   logic [CNT_W-1:0]              rep_run_ff,  rep_run_in;
   logic [CNT_W-1:0]              asc_run_ff,  asc_run_in;
   logic                          rep_viol_ff, rep_viol_in;
   logic                          asc_viol_ff, asc_viol_in;

   logic                          req_accept;
   logic                          first_byte;
   logic                          is_repeat;
   logic                          is_ascending;
   logic [ppc_pkg::MIN_CLS_W-1:0] class_count;
   logic                          ok_in;

   assign req_accept = req_valid & req_ready;
   assign first_byte = (length_ff == '0);

   // Ascending means one above the previous byte taken as a signed value, so
   // a step from 0x7F to 0x80 is not ascending but 0xFF to 0x00 is.
   assign is_repeat    = (req_char_byte == prev_ff);
   assign is_ascending = (prev_ff != 8'h7F) && ((prev_ff + 8'd1) == req_char_byte);

   always_comb begin
      length_in  = (length_ff == CNT_SAT) ? length_ff : length_ff + CNT_ONE;
      classes_in = classes_ff | ppc_pkg::class_of(req_char_byte);

      if (first_byte) begin
         // Both runs start afresh and no run limit is checked on this byte.
         rep_run_in  = CNT_ONE;
         asc_run_in  = CNT_ONE;
         rep_viol_in = rep_viol_ff;
         asc_viol_in = asc_viol_ff;
      end else begin
         if (is_repeat) begin
            rep_run_in = (rep_run_ff == CNT_SAT) ? rep_run_ff : rep_run_ff + CNT_ONE;
         end else begin
            rep_run_in = CNT_ONE;
         end
         if (is_ascending) begin
            asc_run_in = (asc_run_ff == CNT_SAT) ? asc_run_ff : asc_run_ff + CNT_ONE;
         end else begin
            asc_run_in = CNT_ONE;
         end
         rep_viol_in = rep_viol_ff | ((max_repeat_ff != '0) &&
                       (CMP_W'(rep_run_in) > CMP_W'(max_repeat_ff)));
         asc_viol_in = asc_viol_ff | ((max_ascending_ff != '0) &&
                       (CMP_W'(asc_run_in) > CMP_W'(max_ascending_ff)));
      end
   end

   assign class_count = ppc_pkg::MIN_CLS_W'($countones(classes_in));

   // Verdict for the password if this byte is its last one.
   assign ok_in = (CMP_W'(length_in) >= CMP_W'(min_length_ff))
                & (CMP_W'(length_in) <= CMP_W'(max_length_ff))
                & (class_count >= min_classes_ff)
                & ((required_ff & ~classes_in) == '0)
                & ((forbidden_ff & classes_in) == '0)
                & ~rep_viol_in
                & ~asc_viol_in;

   // The state clears once the final byte of a password has been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         classes_ff  <= '0;
         prev_ff     <= '0;
         rep_run_ff  <= '0;
         asc_run_ff  <= '0;
         rep_viol_ff <= 1'b0;
         asc_viol_ff <= 1'b0;
      end else if (req_accept) begin
         if (req_last_byte) begin
            length_ff   <= '0;
            classes_ff  <= '0;
            prev_ff     <= '0;
            rep_run_ff  <= '0;
            asc_run_ff  <= '0;
            rep_viol_ff <= 1'b0;
            asc_viol_ff <= 1'b0;
         end else begin
            length_ff   <= length_in;
            classes_ff  <= classes_in;
            prev_ff     <= req_char_byte;
            rep_run_ff  <= rep_run_in;
            asc_run_ff  <= asc_run_in;
            rep_viol_ff <= rep_viol_in;
            asc_viol_ff <= asc_viol_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result queue: output register with a skid register behind it
   // ------------------------------------------------------------------------
   logic out_valid_ff;
   logic out_ok_ff;
   logic skid_valid_ff;
   logic skid_ok_ff;
   logic out_free;
   logic new_result;

   // The skid entry is only filled while the output entry is held, so a free
   // skid entry is enough to take any request.
   assign req_ready  = ~skid_valid_ff;
   assign out_free   = ~out_valid_ff | rsp_ready;
   assign new_result = req_accept & req_last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= new_result;
         end
      end else if (new_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ok_ff <= skid_valid_ff ? skid_ok_ff : ok_in;
      end
      if (!out_free && new_result) begin
         skid_ok_ff <= ok_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_ok    = out_ok_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ppc_checker.sv
// ----------------------------------------------------------------------------
// Password policy checker assertions
// Port-level checks on the request and response channels, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire                            req_last_byte,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire                            rsp_ok
);

   // A held response keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok))
      else $error("response changed while stalled");

   // No response is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A response only appears after a final byte has been taken.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte))
      else $error("response without a final byte");

   // Requests are only held off while a response is waiting.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with nothing pending");

   // A byte that is not the last one never creates a response.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_byte && !rsp_valid |=> !rsp_valid)
      else $error("response from a non-final byte");

endmodule

bind password_policy_checker_top ppc_checker u_ppc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_ok        (rsp_ok)
);

`default_nettype wire
